FILE: rtl/afc_pkg.sv
package afc_pkg;

    // Fixed field widths
    localparam int COORD_W      = 32;
    localparam int COEF_W       = COORD_W + 1;
    localparam int MAT_REG_W    = 64;
    localparam int NUM_MAT_REGS = 8;
    localparam int CFG_IDX_W    = 4;
    localparam int NUM_PLANES   = 6;
    localparam int BOX_W        = 6 * COORD_W;
    localparam int OUT_DATA_W   = 8;

    // Default fraction bits of the box coordinates
    localparam int COORD_FRAC_BITS_DEF = 16;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] REG_M_R0_A = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_M_R0_B = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_M_R1_A = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_M_R1_B = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_M_R2_A = CFG_IDX_W'(4);
    localparam logic [CFG_IDX_W-1:0] REG_M_R2_B = CFG_IDX_W'(5);
    localparam logic [CFG_IDX_W-1:0] REG_M_R3_A = CFG_IDX_W'(6);
    localparam logic [CFG_IDX_W-1:0] REG_M_R3_B = CFG_IDX_W'(7);

    // Identity matrix in Q16.16
    localparam logic [MAT_REG_W-1:0] ONE_LO = 64'h0000_0000_0001_0000;
    localparam logic [MAT_REG_W-1:0] ONE_HI = 64'h0001_0000_0000_0000;

    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [COEF_W-1:0]  coef_t;

    // One plane: x, y, z normal and w offset
    typedef struct packed {
        coef_t w;
        coef_t z;
        coef_t y;
        coef_t x;
    } plane_t;

    // Box request, min_x in the lowest bits
    typedef struct packed {
        coord_t max_z;
        coord_t max_y;
        coord_t max_x;
        coord_t min_z;
        coord_t min_y;
        coord_t min_x;
    } box_t;

    // Per-stage load enables of the plane pipeline
    typedef struct packed {
        logic s1;
        logic s2;
        logic s3;
        logic s4;
    } stage_en_t;

endpackage

FILE: rtl/afc_plane.sv
module afc_plane #(
    parameter int COORD_FRAC_BITS = afc_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic              clk,
    input  afc_pkg::stage_en_t en,
    input  afc_pkg::plane_t   plane,
    input  afc_pkg::box_t     box,
    output logic              neg
);
    import afc_pkg::*;

    localparam int PROD_W = COEF_W + COORD_W;
    localparam int OFS_W  = COEF_W + COORD_FRAC_BITS;
    localparam int ACC_W  = ((PROD_W > OFS_W) ? PROD_W : OFS_W) + 2;

    coef_t cx, cy, cz, cw;

    coord_t sel_x_reg, sel_y_reg, sel_z_reg;
    coord_t sel_x_next, sel_y_next, sel_z_next;
    logic signed [OFS_W-1:0]  ofs_reg, ofs_next;

    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [PROD_W-1:0] prod_x_next, prod_y_next, prod_z_next;
    logic signed [OFS_W-1:0]  ofs2_reg;

    logic signed [ACC_W-1:0]  sum_a_reg, sum_b_reg, sum_a_next, sum_b_next;
    logic signed [ACC_W-1:0]  total;
    logic                     neg_reg;

    assign cx = $signed(plane.x);
    assign cy = $signed(plane.y);
    assign cz = $signed(plane.z);
    assign cw = $signed(plane.w);

    // Pick the corner furthest along the normal
    always_comb
    begin
        sel_x_next = cx[COEF_W-1] ? box.min_x : box.max_x;
        sel_y_next = cy[COEF_W-1] ? box.min_y : box.max_y;
        sel_z_next = cz[COEF_W-1] ? box.min_z : box.max_z;
        ofs_next   = OFS_W'(cw) <<< COORD_FRAC_BITS;
    end

    // Multiply normal by corner
    always_comb
    begin
        prod_x_next = PROD_W'(cx) * PROD_W'(sel_x_reg);
        prod_y_next = PROD_W'(cy) * PROD_W'(sel_y_reg);
        prod_z_next = PROD_W'(cz) * PROD_W'(sel_z_reg);
    end

    // Pairwise partial sums, then the final sum
    always_comb
    begin
        sum_a_next = ACC_W'(prod_x_reg) + ACC_W'(prod_y_reg);
        sum_b_next = ACC_W'(prod_z_reg) + ACC_W'(ofs2_reg);
        total      = sum_a_reg + sum_b_reg;
    end

    // Advance each stage when its load enable is set
    always_ff @(posedge clk)
    begin
        if (en.s1)
        begin
            sel_x_reg <= sel_x_next;
            sel_y_reg <= sel_y_next;
            sel_z_reg <= sel_z_next;
            ofs_reg   <= ofs_next;
        end
        if (en.s2)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            ofs2_reg   <= ofs_reg;
        end
        if (en.s3)
        begin
            sum_a_reg <= sum_a_next;
            sum_b_reg <= sum_b_next;
        end
        if (en.s4)
        begin
            neg_reg <= total[ACC_W-1];
        end
    end

    assign neg = neg_reg;

endmodule

FILE: rtl/aabb_frustum_cull_core.sv
// Axis-aligned box frustum culling. Each request on the s_ side carries one box
// (six signed coordinates with COORD_FRAC_BITS fraction bits); each box yields
// exactly one result on the m_ side, in order, with m_tdata[0] = 1 when the box
// lies on the inner side of all six planes taken from the view-projection
// matrix (row 3 plus or minus rows 0..2) and 0 when it is culled. A sum of
// exactly zero counts as inside. One box is accepted per cycle unless the
// output stalls; a box passes the box register, then per plane the corner
// select, 33x32 multiply, two adder levels and sign register, then the output
// register, with six plane units (18 multipliers) working in parallel.
// Bubbles are squeezed out and a stalled output holds the pipeline without
// loss. Matrix registers are written through the cfg port (indexes 0 to 7,
// others ignored) by the user only while the block is idle, not enforced by
// the block; the derived plane coefficients are registered. Reset loads identity.
module aabb_frustum_cull_core #(
    parameter int COORD_FRAC_BITS = afc_pkg::COORD_FRAC_BITS_DEF
) (
    input  logic                             clk,
    input  logic                             rst_n,
    // cfg channel
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [afc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [afc_pkg::MAT_REG_W-1:0]    cfg_data,
    // box stream
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // box_min_x, box_min_y, box_min_z, box_max_x, box_max_y, box_max_z
    input  logic [afc_pkg::BOX_W-1:0]        s_tdata,
    // result stream
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // visible, then zero fill
    output logic [afc_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import afc_pkg::*;

    logic [MAT_REG_W-1:0] mat_reg [NUM_MAT_REGS];
    plane_t               plane_reg [NUM_PLANES];
    plane_t               plane_next [NUM_PLANES];

    box_t      box_reg;
    logic      v0_reg, v1_reg, v2_reg, v3_reg, v4_reg, vo_reg;
    logic      ld0, ld1, ld2, ld3, ld4, ld_out;
    stage_en_t en;
    logic [NUM_PLANES-1:0] neg;
    logic      visible_reg;

    // Matrix registers, always ready
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_reg[REG_M_R0_A[2:0]] <= ONE_LO;
            mat_reg[REG_M_R0_B[2:0]] <= '0;
            mat_reg[REG_M_R1_A[2:0]] <= ONE_HI;
            mat_reg[REG_M_R1_B[2:0]] <= '0;
            mat_reg[REG_M_R2_A[2:0]] <= '0;
            mat_reg[REG_M_R2_B[2:0]] <= ONE_LO;
            mat_reg[REG_M_R3_A[2:0]] <= '0;
            mat_reg[REG_M_R3_B[2:0]] <= ONE_HI;
        end
        else if (cfg_valid && (cfg_index <= REG_M_R3_B))
        begin
            mat_reg[cfg_index[2:0]] <= cfg_data;
        end
    end

    // Form planes: row 3 plus (even plane) or minus (odd plane) the chosen row
    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane_coef
        localparam int ROW = p / 2;
        coef_t c [4];
        for (genvar k = 0; k < 4; k++)
        begin : g_col
            localparam int IDX3 = 6 + k / 2;
            localparam int IDXR = ROW * 2 + k / 2;
            localparam int LSB  = (k % 2) * COORD_W;
            coef_t a, b;
            assign a = COEF_W'($signed(mat_reg[IDX3][LSB +: COORD_W]));
            assign b = COEF_W'($signed(mat_reg[IDXR][LSB +: COORD_W]));
            assign c[k] = ((p % 2) == 1) ? (a - b) : (a + b);
        end
        assign plane_next[p].x = c[0];
        assign plane_next[p].y = c[1];
        assign plane_next[p].z = c[2];
        assign plane_next[p].w = c[3];
    end

    always_ff @(posedge clk)
    begin
        for (int p = 0; p < NUM_PLANES; p++)
        begin
            plane_reg[p] <= plane_next[p];
        end
    end

    // Load enables: a stage loads when empty or when its successor loads
    always_comb
    begin
        ld_out = !vo_reg || m_tready;
        ld4    = !v4_reg || ld_out;
        ld3    = !v3_reg || ld4;
        ld2    = !v2_reg || ld3;
        ld1    = !v1_reg || ld2;
        ld0    = !v0_reg || ld1;
        en.s1  = ld1;
        en.s2  = ld2;
        en.s3  = ld3;
        en.s4  = ld4;
    end

    assign s_tready = ld0;

    // Advance valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg <= 1'b0;
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            vo_reg <= 1'b0;
        end
        else
        begin
            if (ld0)
            begin
                v0_reg <= s_tvalid;
            end
            if (ld1)
            begin
                v1_reg <= v0_reg;
            end
            if (ld2)
            begin
                v2_reg <= v1_reg;
            end
            if (ld3)
            begin
                v3_reg <= v2_reg;
            end
            if (ld4)
            begin
                v4_reg <= v3_reg;
            end
            if (ld_out)
            begin
                vo_reg <= v4_reg;
            end
        end
    end

    // Capture the box and the combined verdict
    always_ff @(posedge clk)
    begin
        if (ld0)
        begin
            box_reg <= box_t'(s_tdata);
        end
        if (ld_out)
        begin
            visible_reg <= ~|neg;
        end
    end

    // Six plane units
    for (genvar p = 0; p < NUM_PLANES; p++)
    begin : g_plane
        afc_plane #(
            .COORD_FRAC_BITS(COORD_FRAC_BITS)
        ) u_plane (
            .clk   (clk),
            .en    (en),
            .plane (plane_reg[p]),
            .box   (box_reg),
            .neg   (neg[p])
        );
    end

    assign m_tvalid = vo_reg;
    assign m_tdata  = {{(OUT_DATA_W-1){1'b0}}, visible_reg};

endmodule
